// ===== hdl/bba_pkg.sv =====
// shared types and constants of the block bitmap allocator
package bba_pkg;

  localparam int BLK_W   = 8;
  localparam int CMD_W   = 2;
  localparam int TALLY_W = 9;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  typedef struct packed {
    logic latch;
    logic apply;
  } bba_ctl_t;

endpackage

// ===== hdl/block_bitmap_allocator.sv =====
// top level of the first-fit block bitmap allocator
//
//  channel  direction  tdata                                  tuser
//  s_*      in         [7:0] block_number                     [1:0] cmd
//  m_*      out        [7:0] granted_block, [16:8] free_total [0] ok
//
// each transaction runs in two steps: the first registers the command and the
// word-summary search, the second searches the chosen word and updates the map
// the result register lets the next transaction in while a result waits
// a stalled result holds the update step until the output is taken
// reset is synchronous and marks every block below BLOCK_COUNT free at once
module block_bitmap_allocator #(
  parameter int BLOCK_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] block_number
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] granted_block, [16:8] free_total
  output logic        m_tuser    // [0] ok
);
  import bba_pkg::*;

  bba_ctl_t           ctl;
  logic [BLK_W-1:0]   granted_block;
  logic [TALLY_W-1:0] free_total;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl)
  );

  bba_datapath #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .in_cmd        (s_tuser),
    .in_blk        (s_tdata),
    .granted_block (granted_block),
    .ok            (m_tuser),
    .free_total    (free_total)
  );

  assign m_tdata = {7'd0, free_total, granted_block};

  a_tally_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:8] <= TALLY_W'(BLOCK_COUNT)))
    else $error("free total above block count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (!s_tready))
    else $error("second transaction taken during update");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> ##1 m_tvalid)
    else $error("result missing after transaction");

endmodule

// ===== hdl/bba_ctrl.sv =====
// controller state machine of the block bitmap allocator
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output bba_pkg::bba_ctl_t ctl
);
  import bba_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic state;
  logic state_next;
  logic m_tvalid_next;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    m_tvalid_next = m_tvalid && !m_tready;
    ctl.latch     = 1'b0;
    ctl.apply     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctl.latch  = 1'b1;
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          ctl.apply     = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ===== hdl/bba_datapath.sv =====
// free map, tally, two-level first-free search and result register
module bba_datapath #(
  parameter int BLOCK_COUNT = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bba_pkg::bba_ctl_t           ctl,
  input  logic [bba_pkg::CMD_W-1:0]   in_cmd,
  input  logic [bba_pkg::BLK_W-1:0]   in_blk,
  output logic [bba_pkg::BLK_W-1:0]   granted_block,
  output logic                        ok,
  output logic [bba_pkg::TALLY_W-1:0] free_total
);
  import bba_pkg::*;

  localparam int WORDS = (BLOCK_COUNT + 7) / 8;
  localparam int W_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [TALLY_W-1:0] BC = TALLY_W'(BLOCK_COUNT);

  logic [7:0]         words [WORDS];
  logic [TALLY_W-1:0] tally;
  logic [CMD_W-1:0]   cmd_q;
  logic [BLK_W-1:0]   blk_q;
  logic [W_W-1:0]     word_q;
  logic               found_q;

  logic [W_W-1:0]     enc_word;
  logic               any_free;
  logic [7:0]         sel_word;
  logic [2:0]         enc_bit;
  logic               is_alloc;
  logic               named_ok;
  logic [W_W-1:0]     tgt_word;
  logic [2:0]         tgt_bit;
  logic               cur;
  logic               do_used;
  logic               do_free;
  logic [BLK_W-1:0]   alloc_blk;

  // summary search over words, lowest index wins
  always_comb begin
    enc_word = '0;
    any_free = 1'b0;
    for (int w = WORDS - 1; w >= 0; w--) begin
      if (|words[w]) begin
        enc_word = W_W'(w);
        any_free = 1'b1;
      end
    end
  end

  assign sel_word = words[word_q];

  always_comb begin
    enc_bit = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (sel_word[b]) begin
        enc_bit = 3'(b);
      end
    end
  end

  assign is_alloc  = (cmd_q == CMD_ALLOC);
  assign named_ok  = ((cmd_q == CMD_MARK) || (cmd_q == CMD_RELEASE)) &&
                     ({1'b0, blk_q} < BC);
  assign tgt_word  = is_alloc ? word_q  : blk_q[3 +: W_W];
  assign tgt_bit   = is_alloc ? enc_bit : blk_q[2:0];
  assign cur       = words[tgt_word][tgt_bit];
  assign do_used   = (is_alloc && found_q) || (cmd_q == CMD_MARK && named_ok && cur);
  assign do_free   = (cmd_q == CMD_RELEASE) && named_ok && !cur;
  assign alloc_blk = BLK_W'({word_q, enc_bit});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WORDS; w++) begin
        for (int b = 0; b < 8; b++) begin
          words[w][b] <= ((w * 8 + b) < BLOCK_COUNT);
        end
      end
      tally <= BC;
    end else if (ctl.apply) begin
      if (do_used) begin
        words[tgt_word][tgt_bit] <= 1'b0;
        tally <= tally - TALLY_W'(1);
      end else if (do_free) begin
        words[tgt_word][tgt_bit] <= 1'b1;
        tally <= tally + TALLY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q   <= in_cmd;
      blk_q   <= in_blk;
      word_q  <= enc_word;
      found_q <= any_free;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      if (is_alloc) begin
        granted_block <= found_q ? alloc_blk : '0;
        ok            <= found_q;
      end else begin
        granted_block <= blk_q;
        ok            <= named_ok;
      end
      if (do_used) begin
        free_total <= tally - TALLY_W'(1);
      end else if (do_free) begin
        free_total <= tally + TALLY_W'(1);
      end else begin
        free_total <= tally;
      end
    end
  end

endmodule
